// ----- sv/mrfb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MODBUS RTU frame builder package
// Shared payload types, queue entry, constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrfb_pkg;

  // Frame limits and CRC constants
  localparam int unsigned AduMaxLength = 256;
  localparam int unsigned CountWidth   = 9;
  localparam logic [CountWidth-1:0] CountMax = '1;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [15:0] CrcPoly = 16'hA001;
  localparam logic [7:0]  AddrReset = 8'h01;

  // Queue between front and back
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrWidth  = $clog2(FifoDepth);
  localparam int unsigned LvlWidth  = $clog2(FifoDepth + 1);

  // Input transaction
  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_of_frame;
  } in_item_t;

  // Output transaction
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       overlong;
  } out_item_t;

  // Classified item as handed from front to back
  typedef struct packed {
    logic [7:0] addr;
    logic [7:0] body;
    logic       first;
    logic       last;
  } mrfb_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } mrfb_fifo_status_t;

  // Back-end sequencer states
  typedef enum logic [3:0] {
    ST_START  = 4'b0001,
    ST_BODY   = 4'b0010,
    ST_CRC_LO = 4'b0100,
    ST_CRC_HI = 4'b1000
  } mrfb_state_e;

  // Reflected CRC-16 (poly 0xA001) over one byte
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- sv/mrfb_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MODBUS RTU frame builder front end
// Accepts body bytes, holds the station address register, tags the first
// byte of each frame and pushes classified items into the queue.
// ----------------------------------------------------------------------------
module mrfb_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [7:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  mrfb_pkg::in_item_t         in_item_i,
  input  mrfb_pkg::mrfb_fifo_status_t fifo_status_i,
  output logic                       push_o,
  output mrfb_pkg::mrfb_entry_t      push_data_o
);
  import mrfb_pkg::*;

  logic [7:0] station_address_q;
  logic       in_frame_q, in_frame_d;
  logic       accept;

  // Station address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_address_q <= AddrReset;
    end else if (cfg_we_i) begin
      station_address_q <= cfg_wdata_i;
    end
  end

  // Accept whenever the queue has room
  assign in_stall_o = fifo_status_i.full;
  assign accept     = in_valid_i && !fifo_status_i.full;
  assign push_o     = accept;

  // Classify: first byte of a frame carries the address with it
  always_comb begin
    push_data_o.addr  = station_address_q;
    push_data_o.body  = in_item_i.body_byte;
    push_data_o.first = !in_frame_q;
    push_data_o.last  = in_item_i.last_of_frame;
  end

  // Frame tracking
  always_comb begin
    in_frame_d = in_frame_q;
    if (accept) begin
      in_frame_d = !in_item_i.last_of_frame;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else begin
      in_frame_q <= in_frame_d;
    end
  end

endmodule

// ----- sv/mrfb_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MODBUS RTU frame builder queue
// Short FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module mrfb_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  mrfb_pkg::mrfb_entry_t       push_data_i,
  input  logic                        pop_i,
  output mrfb_pkg::mrfb_entry_t       head_o,
  output mrfb_pkg::mrfb_fifo_status_t status_o
);
  import mrfb_pkg::*;

  mrfb_entry_t          mem_q [FifoDepth];
  logic [PtrWidth-1:0]  wr_ptr_q, rd_ptr_q;
  logic [LvlWidth-1:0]  level_q, level_d;

  assign status_o.full  = (level_q == LvlWidth'(FifoDepth));
  assign status_o.empty = (level_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Fill level
  always_comb begin
    level_d = level_q;
    if (push_i && !pop_i) begin
      level_d = level_q + LvlWidth'(1);
    end else if (pop_i && !push_i) begin
      level_d = level_q - LvlWidth'(1);
    end
  end

  // Pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrWidth'(FifoDepth - 1)) ? '0 : wr_ptr_q + PtrWidth'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrWidth'(FifoDepth - 1)) ? '0 : rd_ptr_q + PtrWidth'(1);
      end
      level_q <= level_d;
    end
  end

endmodule

// ----- sv/mrfb_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MODBUS RTU frame builder back end
// Sequences address, body and CRC bytes from queued items, keeps the CRC
// and the frame byte count, and drives the output register.
// ----------------------------------------------------------------------------
module mrfb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mrfb_pkg::mrfb_entry_t       head_i,
  input  mrfb_pkg::mrfb_fifo_status_t fifo_status_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mrfb_pkg::out_item_t         out_item_o
);
  import mrfb_pkg::*;

  mrfb_state_e           state_q, state_d;
  logic [15:0]           crc_q, crc_d;
  logic [CountWidth-1:0] cnt_q, cnt_d, cnt_inc;
  logic                  out_valid_q;
  out_item_t             out_item_q, out_item_d;
  logic                  load, fire, pop;
  logic                  data_byte;
  logic [7:0]            byte_sel;
  logic                  last_sel;

  // Output slot free when empty or being taken
  assign load  = !out_valid_q || !out_stall_i;
  assign fire  = load && !fifo_status_i.empty;
  assign pop_o = fire && pop;

  assign cnt_inc = (cnt_q == CountMax) ? cnt_q : cnt_q + CountWidth'(1);

  // Byte sequencer
  always_comb begin
    state_d   = state_q;
    pop       = 1'b0;
    data_byte = 1'b1;
    byte_sel  = head_i.body;
    last_sel  = 1'b0;
    case (state_q)
      ST_START: begin
        if (head_i.first) begin
          byte_sel = head_i.addr;
          state_d  = ST_BODY;
        end else if (head_i.last) begin
          state_d = ST_CRC_LO;
        end else begin
          pop = 1'b1;
        end
      end
      ST_BODY: begin
        if (head_i.last) begin
          state_d = ST_CRC_LO;
        end else begin
          state_d = ST_START;
          pop     = 1'b1;
        end
      end
      ST_CRC_LO: begin
        data_byte = 1'b0;
        byte_sel  = crc_q[7:0];
        state_d   = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        data_byte = 1'b0;
        byte_sel  = crc_q[15:8];
        last_sel  = 1'b1;
        state_d   = ST_START;
        pop       = 1'b1;
      end
      default: begin
        state_d   = ST_START;
        data_byte = 1'b0;
      end
    endcase
  end

  // CRC and count next values
  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_inc;
    if (data_byte) begin
      crc_d = crc_update(crc_q, byte_sel);
    end
    if (last_sel) begin
      crc_d = CrcInit;
      cnt_d = '0;
    end
  end

  always_comb begin
    out_item_d.out_byte = byte_sel;
    out_item_d.out_last = last_sel;
    out_item_d.overlong = (cnt_inc > CountWidth'(AduMaxLength));
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_START;
      crc_q       <= CrcInit;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        state_q <= state_d;
        crc_q   <= crc_d;
        cnt_q   <= cnt_d;
      end
      if (load) begin
        out_valid_q <= fire;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- sv/modbus_rtu_frame_builder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MODBUS RTU frame builder
// Turns a stream of message-body bytes into RTU frames: station address,
// body bytes, CRC-16 low and high byte, with an overlong-frame flag.
//
//   Port group   Direction  Handshake              Payload
//   in           input      in_valid_i/in_stall_o  in_item_i (body, last)
//   out          output     out_valid_o/out_stall_i out_item_o (byte, last, overlong)
//   cfg          input      cfg_we_i               cfg_wdata_i (station address)
//
// One output byte leaves per cycle unless out_stall_i is high or the queue is
// empty; the back-end sequencer sets the pace. A mid-frame item yields its body
// byte; a first item adds the address byte before it, a last item the CRC low
// and high bytes after it. A 4-entry queue keeps the front accepting while the
// output stalls. Reset awaits a frame's first byte, with station address at 1.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mrfb_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mrfb_pkg::out_item_t out_item_o
);
  import mrfb_pkg::*;

  mrfb_fifo_status_t fifo_status;
  mrfb_entry_t       push_data, head;
  logic              push, pop;

  mrfb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .fifo_status_i (fifo_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  mrfb_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .status_o    (fifo_status)
  );

  mrfb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .fifo_status_i (fifo_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o)
  );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MODBUS RTU frame builder testbench
// Drives body-byte transactions into the frame builder and compares every
// emitted frame byte against an in-bench frame model (address insertion,
// CRC-16 low/high bytes, end mark, overlong flag). Directed tests cover
// byte and address extremes, a mid-frame address write and a frame that
// crosses the ADU limit; random frames run under three idle mixes plus a
// backpressure test that fills the block.
// ----------------------------------------------------------------------------
module tb;

  import mrfb_pkg::*;

  // Run control
  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 12;
  localparam int MaxGap      = 20;
  localparam logic [15:0] Crc16Poly = 16'hA001;
  localparam int CountSat    = 511;

  // DUT signals
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_wdata_i;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_item_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_item_o;

  // Frame model state
  logic [7:0]  station_addr_q;
  logic [15:0] mdl_crc;
  logic        mdl_in_frame;
  int          mdl_count;
  out_item_t   exp_frame_bytes[$];

  // Traffic shaping
  int in_idle_pct;
  int out_idle_pct;
  int hold_cycles_req;

  // Bookkeeping
  int errors;
  int items_sent;
  int bytes_checked;
  int frames_built;
  int addr_writes;
  int overlong_seen;
  int cycle_count;

  modbus_rtu_frame_builder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Mismatches found");
    $finish;
  end

  // Reflected CRC-16 over one byte, bit-serial
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ Crc16Poly) : (c >> 1);
    end
    return c;
  endfunction

  // Queue one expected frame byte and advance the position count
  task automatic push_frame_byte(input logic [7:0] b, input logic last);
    out_item_t e;
    if (mdl_count < CountSat) mdl_count++;
    e.out_byte = b;
    e.out_last = last;
    e.overlong = (mdl_count > AduMaxLength);
    exp_frame_bytes.push_back(e);
  endtask

  // Expected frame bytes caused by one accepted body byte
  task automatic predict_frame_bytes(input in_item_t it);
    if (!mdl_in_frame) begin
      mdl_crc = crc16_step(CrcInit, station_addr_q);
      mdl_count = 0;
      push_frame_byte(station_addr_q, 1'b0);
      mdl_in_frame = 1'b1;
    end
    mdl_crc = crc16_step(mdl_crc, it.body_byte);
    push_frame_byte(it.body_byte, 1'b0);
    if (it.last_of_frame) begin
      push_frame_byte(mdl_crc[7:0], 1'b0);
      push_frame_byte(mdl_crc[15:8], 1'b1);
      mdl_crc = CrcInit;
      mdl_in_frame = 1'b0;
      mdl_count = 0;
      frames_built++;
    end
  endtask

  // Predict on input transactions, check output transactions
  always @(posedge clk_i) begin : scoreboard
    out_item_t exp_item;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) predict_frame_bytes(in_item_i);
      if (out_valid_o && !out_stall_i) begin
        bytes_checked++;
        if (out_item_o.overlong) overlong_seen++;
        if (exp_frame_bytes.size() == 0) begin
          errors++;
          $display("%0t: unexpected byte: expected none, actual byte %02h last %b overlong %b",
                   $time, out_item_o.out_byte, out_item_o.out_last, out_item_o.overlong);
        end else begin
          exp_item = exp_frame_bytes.pop_front();
          if (out_item_o.out_byte !== exp_item.out_byte) begin
            errors++;
            $display("%0t: out_byte mismatch: expected %02h actual %02h",
                     $time, exp_item.out_byte, out_item_o.out_byte);
          end
          if (out_item_o.out_last !== exp_item.out_last) begin
            errors++;
            $display("%0t: out_last mismatch: expected %b actual %b",
                     $time, exp_item.out_last, out_item_o.out_last);
          end
          if (out_item_o.overlong !== exp_item.overlong) begin
            errors++;
            $display("%0t: overlong mismatch: expected %b actual %b",
                     $time, exp_item.overlong, out_item_o.overlong);
          end
        end
      end
    end
  end

  // Receiver: random stall plus long hold-off on request
  always @(negedge clk_i) begin : receiver
    int hold_left;
    if (hold_cycles_req > 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left > 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      out_stall_i = ($urandom_range(99) < out_idle_pct);
    end
  end

  // Send one body byte; called and returns at a falling edge
  task automatic send_body_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = 0;
    while (($urandom_range(99) < in_idle_pct) && (gap < MaxGap)) gap++;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      in_item_i  = in_item_t'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i.body_byte = b;
    in_item_i.last_of_frame = last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // Stop sending and wait until every expected byte has left
  task automatic wait_frames_drained();
    in_valid_i = 1'b0;
    while (exp_frame_bytes.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Station address write; block must be idle
  task automatic write_station_address(input logic [7:0] a);
    cfg_we_i = 1'b1;
    cfg_wdata_i = a;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'($urandom);
    station_addr_q = a;
    addr_writes++;
  endtask

  // Frame of random body bytes
  task automatic send_random_frame(input int len);
    for (int k = 0; k < len; k++) send_body_byte(8'($urandom), k == len - 1);
  endtask

  // Reset address value, single-byte frame
  task automatic test_default_address();
    send_body_byte(8'h00, 1'b1);
    send_body_byte(8'h01, 1'b0);
    send_body_byte(8'h03, 1'b1);
    wait_frames_drained();
  endtask

  // Byte and address extremes, including an address above the legal range
  task automatic test_byte_extremes();
    write_station_address(8'd0);
    send_body_byte(8'hFF, 1'b0);
    send_body_byte(8'h00, 1'b1);
    wait_frames_drained();
    write_station_address(8'd247);
    send_body_byte(8'h55, 1'b0);
    send_body_byte(8'hAA, 1'b0);
    send_body_byte(8'hFF, 1'b1);
    wait_frames_drained();
    write_station_address(8'hFF);
    send_body_byte(8'hFF, 1'b1);
    send_body_byte(8'h00, 1'b1);
    wait_frames_drained();
  endtask

  // Address written mid-frame applies from the next frame
  task automatic test_address_mid_frame();
    write_station_address(8'h11);
    send_body_byte(8'h03, 1'b0);
    wait_frames_drained();
    write_station_address(8'h22);
    send_body_byte(8'h00, 1'b0);
    send_body_byte(8'h01, 1'b1);
    send_body_byte(8'h06, 1'b1);
    wait_frames_drained();
  endtask

  // Frame crossing the ADU limit on its last body byte, still emitted with
  // CRC; the short frame after it must start unflagged
  task automatic test_overlong_frame();
    write_station_address(8'($urandom_range(247)));
    send_random_frame(AduMaxLength);
    send_random_frame(3);
    wait_frames_drained();
  endtask

  // Long receiver hold-off fills the block, then sender pauses to drain
  task automatic test_backpressure();
    in_idle_pct = 0;
    out_idle_pct = 0;
    hold_cycles_req = 80;
    send_random_frame(6);
    send_random_frame(1);
    send_random_frame(12);
    send_random_frame(1);
    wait_frames_drained();
  endtask

  // Random frames under one idle mix; mostly short frames
  task automatic run_random_phase(input int s_pct, input int r_pct, input logic [7:0] addr,
                                  input int n_items);
    int start;
    int len;
    in_idle_pct = s_pct;
    out_idle_pct = r_pct;
    wait_frames_drained();
    write_station_address(addr);
    start = items_sent;
    while (items_sent - start < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(6, 1);
      send_random_frame(len);
      if ($urandom_range(7) == 0) begin
        wait_frames_drained();
        write_station_address(8'($urandom));
      end
    end
    wait_frames_drained();
  endtask

  task automatic test_random_frames();
    run_random_phase(35, 73, 8'($urandom_range(247)), 8);
    run_random_phase(73, 35, 8'($urandom), 8);
    run_random_phase(0, 0, 8'($urandom_range(247)), 8);
  endtask

  // Sequence
  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = 8'h00;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_stall_i = 1'b0;
    station_addr_q = AddrReset;
    mdl_crc = CrcInit;
    mdl_in_frame = 1'b0;
    mdl_count = 0;
    in_idle_pct = 35;
    out_idle_pct = 73;
    hold_cycles_req = 0;
    errors = 0;
    items_sent = 0;
    bytes_checked = 0;
    frames_built = 0;
    addr_writes = 0;
    overlong_seen = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_address();
    test_byte_extremes();
    test_address_mid_frame();
    test_overlong_frame();
    test_backpressure();
    test_random_frames();

    wait_frames_drained();
    $display("Run covered %0d body bytes in %0d frames, %0d frame bytes checked (%0d overlong).",
             items_sent, frames_built, bytes_checked, overlong_seen);
    $display("Station address written %0d times; idle mixes 35/73, 73/35, 0/0 and a hold-off.",
             addr_writes);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mrfb_pkg.sv
sv/mrfb_front.sv
sv/mrfb_fifo.sv
sv/mrfb_back.sv
sv/modbus_rtu_frame_builder.sv
dv/tb.sv
